[rtl/hts_pkg.sv]
`timescale 1ns / 1ps

package hts_pkg;

    // Grid size limit and derived storage geometry
    localparam int GRID_MAX   = 256;
    localparam int GRID_DEPTH = GRID_MAX * GRID_MAX;
    localparam int IDX_W      = $clog2(GRID_MAX);
    localparam int ADDR_W     = $clog2(GRID_DEPTH);

    // Fixed-point constants
    localparam logic [16:0] ONE_Q16 = 17'h10000;

    // Configuration register indexes
    localparam logic [2:0] REG_ORIGIN_X      = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Z      = 3'd1;
    localparam logic [2:0] REG_INV_CELL_SIZE = 3'd2;
    localparam logic [2:0] REG_GRID_POINTS   = 3'd3;
    localparam logic [2:0] REG_MAX_HEIGHT    = 3'd4;

    // Opcodes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_z;
        logic        [31:0] inv_cell_size;
        logic        [8:0]  grid_points;
        logic        [7:0]  max_height;
    } cfg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WR,
        S_DIFF,
        S_MX,
        S_MZ,
        S_CHK,
        S_RD0,
        S_RD1,
        S_RD2,
        S_ACC,
        S_SCALE
    } state_t;

    // Linear store address of grid point (col, row)
    function automatic logic [ADDR_W-1:0] grid_addr(input logic [IDX_W-1:0] col,
                                                     input logic [IDX_W-1:0] row);
        logic [ADDR_W-1:0] r;
        r = ADDR_W'(row) * ADDR_W'(GRID_MAX);
        return r + ADDR_W'(col);
    endfunction

endpackage

[rtl/heightmap_triangle_sampler.sv]
`timescale 1ns / 1ps
// Heightmap triangle sampler.
// Input channel: drive opcode and its fields with start high; the word is
// taken at a rising edge where start is high and busy is low. A load word
// (opcode 0) stores load_value at (load_col, load_row); a query word
// (opcode 1) samples the height at (world_x, world_z), both Q16.16.
// Result channel: done pulses high for one cycle with height (Q16.8) and
// out_of_range; every word yields exactly one result. The receiver cannot
// stall, so the result must be taken in that cycle.
// busy stays high until the result is presented, so one word is in flight
// at a time and the next can be accepted in the cycle done is high. A
// query's sequence is set by the single read port of the height store
// (three corner reads) and the multiply steps of the locate and blend
// sequence.
// Configuration: cfg_we, cfg_index, cfg_data write a register at once;
// write only while busy is low. Reset restores register defaults and
// idles the sequencer; the height store is not cleared and must be
// loaded before use.
module heightmap_triangle_sampler (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               opcode,
    input  logic [7:0]         load_col,
    input  logic [7:0]         load_row,
    input  logic [7:0]         load_value,
    input  logic signed [31:0] world_x,
    input  logic signed [31:0] world_z,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output logic               done,
    output logic [23:0]        height,
    output logic               out_of_range
);

    import hts_pkg::*;

    cfg_t              cfg_reg;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [7:0]        ram_wdata;
    logic [7:0]        ram_rdata;

    // Configuration registers; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_x      <= 32'sd0;
            cfg_reg.origin_z      <= 32'sd0;
            cfg_reg.inv_cell_size <= 32'd167116;
            cfg_reg.grid_points   <= 9'd256;
            cfg_reg.max_height    <= 8'd5;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ORIGIN_X:      cfg_reg.origin_x      <= cfg_data;
                REG_ORIGIN_Z:      cfg_reg.origin_z      <= cfg_data;
                REG_INV_CELL_SIZE: cfg_reg.inv_cell_size <= cfg_data;
                REG_GRID_POINTS:   cfg_reg.grid_points   <= cfg_data[8:0];
                REG_MAX_HEIGHT:    cfg_reg.max_height    <= cfg_data[7:0];
                default:           cfg_reg.max_height    <= cfg_reg.max_height;
            endcase
        end
    end

    // Height store
    hts_ram #(
        .WIDTH (8),
        .DEPTH (GRID_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Sequencer and datapath
    hts_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .load_col     (load_col),
        .load_row     (load_row),
        .load_value   (load_value),
        .world_x      (world_x),
        .world_z      (world_z),
        .ram_we       (ram_we),
        .ram_addr     (ram_addr),
        .ram_wdata    (ram_wdata),
        .ram_rdata    (ram_rdata),
        .done         (done),
        .height       (height),
        .out_of_range (out_of_range)
    );

endmodule

[rtl/hts_ram.sv]
`timescale 1ns / 1ps

module hts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write on enable, register the read word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/hts_core.sv]
`timescale 1ns / 1ps

module hts_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  hts_pkg::cfg_t             cfg,
    input  logic                      start,
    output logic                      busy,
    input  logic                      opcode,
    input  logic [7:0]                load_col,
    input  logic [7:0]                load_row,
    input  logic [7:0]                load_value,
    input  logic signed [31:0]        world_x,
    input  logic signed [31:0]        world_z,
    output logic                      ram_we,
    output logic [hts_pkg::ADDR_W-1:0] ram_addr,
    output logic [7:0]                ram_wdata,
    input  logic [7:0]                ram_rdata,
    output logic                      done,
    output logic [23:0]               height,
    output logic                      out_of_range
);

    import hts_pkg::*;

    state_t state_reg;
    state_t state_next;

    // Item words held for the duration of one item
    logic [7:0]         col_reg;
    logic [7:0]         row_reg;
    logic [7:0]         val_reg;
    logic signed [31:0] wx_reg;
    logic signed [31:0] wz_reg;

    // Locate datapath
    logic               neg_x_reg;
    logic               neg_z_reg;
    logic [31:0]        mag_x_reg;
    logic [31:0]        mag_z_reg;
    logic [63:0]        px_reg;
    logic [63:0]        pz_reg;

    // Blend datapath
    logic [ADDR_W-1:0]  addr0_reg;
    logic [ADDR_W-1:0]  addr1_reg;
    logic [ADDR_W-1:0]  addr2_reg;
    logic [16:0]        w0_reg;
    logic [16:0]        w1_reg;
    logic [16:0]        w2_reg;
    logic [24:0]        acc_reg;

    // Result word
    logic               done_reg;
    logic               done_next;
    logic [23:0]        height_reg;
    logic               oor_reg;

    logic               load_ok;
    logic signed [32:0] dx;
    logic signed [32:0] dz;
    logic [32:0]        dx_neg;
    logic [32:0]        dz_neg;
    logic [32:0]        n_pts;
    logic [32:0]        lim;
    logic               small_grid;
    logic               bad_x;
    logic               bad_z;
    logic               chk_oor;
    logic [IDX_W-1:0]   cx;
    logic [IDX_W-1:0]   cz;
    logic [16:0]        fx;
    logic [16:0]        fz;
    logic [16:0]        fsum;
    logic               lower_tri;
    logic [16:0]        wsel;
    logic [24:0]        wprod;
    logic [32:0]        scaled;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = (opcode == OP_LOAD) ? S_WR : S_DIFF;
                end
            end
            S_WR:    state_next = S_IDLE;
            S_DIFF:  state_next = S_MX;
            S_MX:    state_next = S_MZ;
            S_MZ:    state_next = S_CHK;
            S_CHK:   state_next = chk_oor ? S_IDLE : S_RD0;
            S_RD0:   state_next = S_RD1;
            S_RD1:   state_next = S_RD2;
            S_RD2:   state_next = S_ACC;
            S_ACC:   state_next = S_SCALE;
            S_SCALE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs: store port and result strobe
    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = addr0_reg;
        ram_wdata = val_reg;
        done_next = 1'b0;
        wsel      = w0_reg;
        case (state_reg)
            S_WR:
            begin
                ram_we    = load_ok;
                ram_addr  = grid_addr(IDX_W'(col_reg), IDX_W'(row_reg));
                done_next = 1'b1;
            end
            S_CHK:   done_next = chk_oor;
            S_RD0:   ram_addr = addr0_reg;
            S_RD1:
            begin
                ram_addr = addr1_reg;
                wsel     = w0_reg;
            end
            S_RD2:
            begin
                ram_addr = addr2_reg;
                wsel     = w1_reg;
            end
            S_ACC:   wsel = w2_reg;
            S_SCALE: done_next = 1'b1;
            default: ram_addr = addr0_reg;
        endcase
    end

    // Drop writes that fall outside the store
    assign load_ok = ({24'd0, col_reg} < 32'(GRID_MAX)) && ({24'd0, row_reg} < 32'(GRID_MAX));

    // Offset from origin, sign and magnitude
    assign dx     = {wx_reg[31], wx_reg} - {cfg.origin_x[31], cfg.origin_x};
    assign dz     = {wz_reg[31], wz_reg} - {cfg.origin_z[31], cfg.origin_z};
    assign dx_neg = 33'd0 - dx;
    assign dz_neg = 33'd0 - dz;

    // Range check on the scaled grid position
    assign n_pts      = ({24'd0, cfg.grid_points} > 33'(GRID_MAX)) ? 33'(GRID_MAX)
                                                                   : {24'd0, cfg.grid_points};
    assign small_grid = n_pts < 33'd2;
    assign lim        = n_pts - 33'd1;
    assign bad_x      = (neg_x_reg && (px_reg != 64'd0)) || ({1'b0, px_reg[63:32]} >= lim);
    assign bad_z      = (neg_z_reg && (pz_reg != 64'd0)) || ({1'b0, pz_reg[63:32]} >= lim);
    assign chk_oor    = small_grid || bad_x || bad_z;

    // Cell, fraction and triangle choice
    assign cx        = px_reg[32 +: IDX_W];
    assign cz        = pz_reg[32 +: IDX_W];
    assign fx        = {1'b0, px_reg[31:16]};
    assign fz        = {1'b0, pz_reg[31:16]};
    assign fsum      = fx + fz;
    assign lower_tri = fsum <= ONE_Q16;

    // One weight times one sample per cycle
    assign wprod  = 25'(wsel) * 25'(ram_rdata);
    assign scaled = 33'(acc_reg) * 33'(cfg.max_height);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                col_reg <= load_col;
                row_reg <= load_row;
                val_reg <= load_value;
                wx_reg  <= world_x;
                wz_reg  <= world_z;
            end
            S_WR:
            begin
                height_reg <= 24'd0;
                oor_reg    <= 1'b0;
            end
            S_DIFF:
            begin
                neg_x_reg <= dx[32];
                neg_z_reg <= dz[32];
                mag_x_reg <= dx[32] ? dx_neg[31:0] : dx[31:0];
                mag_z_reg <= dz[32] ? dz_neg[31:0] : dz[31:0];
            end
            S_MX: px_reg <= 64'(mag_x_reg) * 64'(cfg.inv_cell_size);
            S_MZ: pz_reg <= 64'(mag_z_reg) * 64'(cfg.inv_cell_size);
            S_CHK:
            begin
                height_reg <= 24'd0;
                oor_reg    <= 1'b1;
                if (lower_tri)
                begin
                    addr0_reg <= grid_addr(cx, cz);
                    addr1_reg <= grid_addr(cx + IDX_W'(1), cz);
                    addr2_reg <= grid_addr(cx, cz + IDX_W'(1));
                    w0_reg    <= ONE_Q16 - fsum;
                    w1_reg    <= fx;
                    w2_reg    <= fz;
                end
                else
                begin
                    addr0_reg <= grid_addr(cx + IDX_W'(1), cz);
                    addr1_reg <= grid_addr(cx + IDX_W'(1), cz + IDX_W'(1));
                    addr2_reg <= grid_addr(cx, cz + IDX_W'(1));
                    w0_reg    <= ONE_Q16 - fz;
                    w1_reg    <= fsum - ONE_Q16;
                    w2_reg    <= ONE_Q16 - fx;
                end
            end
            S_RD1: acc_reg <= wprod;
            S_RD2: acc_reg <= acc_reg + wprod;
            S_ACC: acc_reg <= acc_reg + wprod;
            S_SCALE:
            begin
                height_reg <= scaled[31:8];
                oor_reg    <= 1'b0;
            end
            default: acc_reg <= acc_reg;
        endcase
    end

    assign busy         = state_reg != S_IDLE;
    assign done         = done_reg;
    assign height       = height_reg;
    assign out_of_range = oor_reg;

endmodule

[test/heightmap_triangle_sampler_test.sv]
`timescale 1ns / 1ps

module heightmap_triangle_sampler_test;

    import hts_pkg::*;

    localparam int CYCLE_LIMIT = 400_000;
    localparam int SETTLE_CYCLES = 16;
    localparam logic [2:0] REG_UNUSED = 3'd5;

    // One input word as presented on the command ports
    typedef struct {
        logic               op;
        logic [7:0]         col;
        logic [7:0]         row;
        logic [7:0]         val;
        logic signed [31:0] wx;
        logic signed [31:0] wz;
        bit                 hold;
    } word_t;

    typedef struct {
        logic [23:0] height;
        logic        oor;
    } sample_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               opcode = OP_LOAD;
    logic [7:0]         load_col = '0;
    logic [7:0]         load_row = '0;
    logic [7:0]         load_value = '0;
    logic signed [31:0] world_x = '0;
    logic signed [31:0] world_z = '0;
    logic               cfg_we = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;
    logic               busy;
    logic               done;
    logic [23:0]        height;
    logic               out_of_range;

    // Predictor state: its own copy of the terrain and the registers
    cfg_t      terrain_cfg;
    bit [7:0]  terrain [GRID_DEPTH];
    bit        loaded_ahead [GRID_DEPTH];

    word_t     pending_words [$];
    sample_t   expected_heights [$];
    word_t     next_word;
    word_t     seen_word;
    sample_t   want;
    bit        word_taken = 1'b0;
    int        sender_idle = 0;
    int        mismatches = 0;
    int        cycles = 0;

    heightmap_triangle_sampler u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .load_col     (load_col),
        .load_row     (load_row),
        .load_value   (load_value),
        .world_x      (world_x),
        .world_z      (world_z),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .done         (done),
        .height       (height),
        .out_of_range (out_of_range)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Map one axis to a cell and a Q0.16 fraction; 0 when off the grid
    function automatic bit axis_cell(input logic signed [31:0] w,
                                     input logic signed [31:0] o,
                                     input int unsigned lim,
                                     output int unsigned cell_idx,
                                     output int unsigned frac);
        longint   d;
        bit [63:0] mag;
        bit [63:0] p;
        d = longint'(w) - longint'(o);
        mag = (d < 0) ? 64'(-d) : 64'(d);
        p = mag * {32'b0, terrain_cfg.inv_cell_size};
        cell_idx = 0;
        frac = 0;
        if (d < 0 && p != 0)
            return 1'b0;
        if (p[63:32] >= lim)
            return 1'b0;
        cell_idx = p[63:32];
        frac = {16'd0, p[31:16]};
        return 1'b1;
    endfunction

    function automatic bit grid_cell(input logic signed [31:0] wx,
                                     input logic signed [31:0] wz,
                                     output int unsigned cx, output int unsigned cz,
                                     output int unsigned fx, output int unsigned fz);
        int unsigned n;
        bit          in_x;
        bit          in_z;
        n = (terrain_cfg.grid_points > GRID_MAX) ? GRID_MAX : 32'(terrain_cfg.grid_points);
        cx = 0;
        cz = 0;
        fx = 0;
        fz = 0;
        if (n < 2)
            return 1'b0;
        in_x = axis_cell(wx, terrain_cfg.origin_x, n - 1, cx, fx);
        in_z = axis_cell(wz, terrain_cfg.origin_z, n - 1, cz, fz);
        return in_x && in_z;
    endfunction

    // Apply one word to the terrain copy and return the sample it yields
    function automatic sample_t predict_height(input word_t w);
        sample_t         r;
        int unsigned     cx, cz, fx, fz;
        longint unsigned sum;
        bit [7:0]        h00, h10, h01, h11;
        r.height = '0;
        r.oor = 1'b0;
        if (w.op == OP_LOAD)
        begin
            terrain[int'(w.row) * GRID_MAX + int'(w.col)] = w.val;
        end
        else if (!grid_cell(w.wx, w.wz, cx, cz, fx, fz))
        begin
            r.oor = 1'b1;
        end
        else
        begin
            h00 = terrain[cz * GRID_MAX + cx];
            h10 = terrain[cz * GRID_MAX + cx + 1];
            h01 = terrain[(cz + 1) * GRID_MAX + cx];
            h11 = terrain[(cz + 1) * GRID_MAX + cx + 1];
            // lower triangle includes the anti-diagonal itself
            if (fx + fz <= 65536)
                sum = 64'(65536 - fx - fz) * h00 + 64'(fx) * h10 + 64'(fz) * h01;
            else
                sum = 64'(65536 - fz) * h10 + 64'(fx + fz - 65536) * h11
                    + 64'(65536 - fx) * h01;
            r.height = 24'((sum * terrain_cfg.max_height) >> 8);
        end
        return r;
    endfunction

    function automatic word_t random_word();
        word_t w;
        w.op = 1'($urandom_range(0, 1));
        w.col = 8'($urandom);
        w.row = 8'($urandom);
        w.val = 8'($urandom);
        w.wx = $urandom;
        w.wz = $urandom;
        w.hold = ($urandom_range(0, 99) < 3);
        return w;
    endfunction

    // World coordinate whose grid position starts at cell_idx.part (Q32.32)
    function automatic logic [31:0] world_at(input int unsigned cell_idx,
                                             input logic [31:0] part,
                                             input logic [31:0] origin);
        bit [63:0] gp;
        bit [63:0] d;
        if (terrain_cfg.inv_cell_size == 0)
            return origin + $urandom_range(0, 65535);
        gp = {cell_idx, part};
        d = (gp + terrain_cfg.inv_cell_size - 1) / terrain_cfg.inv_cell_size;
        return origin + d[31:0];
    endfunction

    function automatic int unsigned pick_cell(input int unsigned lim);
        int unsigned r;
        r = $urandom_range(0, 11);
        if (r == 0)
            return 0;
        if (r == 1)
            return lim - 1;
        if (r == 2)
            return lim;
        return $urandom_range(0, lim - 1);
    endfunction

    task automatic queue_load(input logic [7:0] col, input logic [7:0] row,
                              input logic [7:0] val);
        word_t w;
        w = random_word();
        w.op = OP_LOAD;
        w.col = col;
        w.row = row;
        w.val = val;
        loaded_ahead[int'(row) * GRID_MAX + int'(col)] = 1'b1;
        pending_words.push_back(w);
    endtask

    // Queue a query, loading first any corner of its cell not yet written
    task automatic queue_query(input logic [31:0] wx, input logic [31:0] wz);
        word_t       w;
        int unsigned cx, cz, fx, fz;
        w = random_word();
        w.op = OP_QUERY;
        w.wx = wx;
        w.wz = wz;
        if (grid_cell(wx, wz, cx, cz, fx, fz))
        begin
            for (int dz = 0; dz < 2; dz++)
                for (int dx = 0; dx < 2; dx++)
                    if (!loaded_ahead[(cz + dz) * GRID_MAX + cx + dx])
                        queue_load(8'(cx + dx), 8'(cz + dz), 8'($urandom));
        end
        pending_words.push_back(w);
    endtask

    task automatic queue_cell(input int unsigned cx, input int unsigned cz,
                              input logic [31:0] px, input logic [31:0] pz);
        queue_query(world_at(cx, px, terrain_cfg.origin_x),
                    world_at(cz, pz, terrain_cfg.origin_z));
    endtask

    task automatic queue_random(input int count);
        int unsigned n;
        int          k;
        for (int i = 0; i < count; i++)
        begin
            n = (terrain_cfg.grid_points > GRID_MAX) ? GRID_MAX
                                                     : 32'(terrain_cfg.grid_points);
            k = $urandom_range(0, 99);
            if (k < 18)
                queue_load(8'($urandom), 8'($urandom), 8'($urandom));
            else if (k < 28 || n < 2)
                queue_query($urandom, $urandom);
            else if (k < 34)
                queue_query(terrain_cfg.origin_x - $urandom_range(1, 4096),
                            world_at(pick_cell(n - 1), $urandom, terrain_cfg.origin_z));
            else
                queue_cell(pick_cell(n - 1), pick_cell(n - 1), $urandom, $urandom);
        end
    endtask

    // Hold until no word is queued, in flight or owed
    task automatic drain();
        do
            @(negedge clk) #1;
        while (pending_words.size() != 0 || start || word_taken
               || expected_heights.size() != 0 || busy);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            REG_ORIGIN_X:      terrain_cfg.origin_x = data;
            REG_ORIGIN_Z:      terrain_cfg.origin_z = data;
            REG_INV_CELL_SIZE: terrain_cfg.inv_cell_size = data;
            REG_GRID_POINTS:   terrain_cfg.grid_points = data[8:0];
            REG_MAX_HEIGHT:    terrain_cfg.max_height = data[7:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(input logic [31:0] ox, input logic [31:0] oz,
                              input logic [31:0] inv, input logic [8:0] gp,
                              input logic [7:0] mh);
        drain();
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Z, oz);
        write_reg(REG_INV_CELL_SIZE, inv);
        write_reg(REG_GRID_POINTS, ($urandom & 32'hFFFF_FE00) | 32'(gp));
        write_reg(REG_MAX_HEIGHT, ($urandom & 32'hFFFF_FF00) | 32'(mh));
    endtask

    task automatic random_config();
        logic [31:0] rx;
        logic [31:0] rz;
        rx = $urandom;
        rz = $urandom;
        set_config({{8{rx[23]}}, rx[23:0]}, {{8{rz[23]}}, rz[23:0]},
                   $urandom_range(1 << 12, 1 << 22), 9'($urandom_range(2, 256)),
                   8'($urandom_range(1, 255)));
    endtask

    // Drive the next word at the falling edge once the current one is taken
    always @(negedge clk)
    begin
        if (rst_n && (!start || word_taken))
        begin
            word_taken = 1'b0;
            if (pending_words.size() == 0 || $urandom_range(0, 99) < sender_idle
                || (pending_words[0].hold && expected_heights.size() != 0))
            begin
                start <= 1'b0;
            end
            else
            begin
                next_word = pending_words.pop_front();
                start <= 1'b1;
                opcode <= next_word.op;
                load_col <= next_word.col;
                load_row <= next_word.row;
                load_value <= next_word.val;
                world_x <= next_word.wx;
                world_z <= next_word.wz;
            end
        end
    end

    // Check each result, then predict the word taken at this edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("[heightmap_triangle_sampler] ERROR");
                $finish;
            end
            else
            begin
                if (done)
                begin
                    if (expected_heights.size() == 0)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("unexpected result: height %h oor %b",
                                     height, out_of_range);
                    end
                    else
                    begin
                        want = expected_heights.pop_front();
                        if (height !== want.height || out_of_range !== want.oor)
                        begin
                            mismatches++;
                            if (mismatches <= 10)
                                $display("mismatch: expected height %h oor %b, got %h oor %b",
                                         want.height, want.oor, height, out_of_range);
                        end
                    end
                end
                if (start && !busy)
                begin
                    seen_word.op = opcode;
                    seen_word.col = load_col;
                    seen_word.row = load_row;
                    seen_word.val = load_value;
                    seen_word.wx = world_x;
                    seen_word.wz = world_z;
                    seen_word.hold = 1'b0;
                    expected_heights.push_back(predict_height(seen_word));
                    word_taken = 1'b1;
                end
            end
        end
    end

    initial
    begin
        terrain_cfg.origin_x = '0;
        terrain_cfg.origin_z = '0;
        terrain_cfg.inv_cell_size = 32'd167116;
        terrain_cfg.grid_points = 9'd256;
        terrain_cfg.max_height = 8'd5;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: corner loads, far points, last cell and past the edge
        sender_idle = 34;
        queue_load(8'd0, 8'd0, 8'd0);
        queue_load(8'd255, 8'd255, 8'd255);
        queue_load(8'd255, 8'd0, 8'hA5);
        queue_load(8'd0, 8'd255, 8'h5A);
        queue_query(32'h8000_0000, 32'h7FFF_FFFF);
        queue_query(32'h7FFF_FFFF, 32'h8000_0000);
        queue_query(32'h0000_0000, 32'h0000_0000);
        queue_cell(254, 254, 32'hFFFF_0000, 32'h0000_0000);
        queue_cell(255, 3, 32'h0, 32'h0);
        queue_cell(5, 255, 32'h0, 32'h0);
        queue_random(40);

        // Unit cell size: exact fractions on the triangle split
        set_config(32'hFFFB_0000, 32'h0003_8000, 32'h0001_0000, 9'd17, 8'd255);
        write_reg(REG_UNUSED, $urandom);
        queue_cell(3, 4, 32'h8000_0000, 32'h8000_0000);
        queue_cell(3, 4, 32'h8000_0000, 32'h8001_0000);
        queue_cell(15, 15, 32'hFFFF_0000, 32'hFFFF_0000);
        queue_cell(0, 0, 32'h0, 32'h0);
        queue_cell(16, 0, 32'h0, 32'h0);
        queue_random(40);

        // Extreme origins, largest reciprocal, smallest grid
        set_config(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 9'd2, 8'd1);
        queue_query(32'h8000_0000, 32'h7FFF_FFFF);
        queue_query(32'h8000_0001, 32'h7FFF_FFFF);
        queue_query(32'h8000_0002, 32'h8000_0000);
        queue_random(30);

        // Zero reciprocal, oversized grid, zero height scale
        sender_idle = 61;
        set_config(32'h0001_0000, 32'hFFFF_0000, 32'h0, 9'h1FF, 8'd0);
        queue_query(32'h0000_0000, 32'h8000_0000);
        queue_query(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        queue_random(40);

        // Grids too small to hold a cell
        set_config(32'h0, 32'h0, 32'h0001_0000, 9'd0, 8'd200);
        queue_random(20);
        set_config(32'h0, 32'h0, 32'h0001_0000, 9'd1, 8'd200);
        queue_random(20);

        random_config();
        queue_random(40);

        sender_idle = 0;
        random_config();
        queue_random(40);

        set_config(32'h0, 32'h0, 32'h0001_0000, 9'd256, 8'd128);
        queue_random(30);

        drain();
        repeat (SETTLE_CYCLES) @(negedge clk);
        mismatches += expected_heights.size();
        if (mismatches == 0)
            $display("[heightmap_triangle_sampler] OK");
        else
            $display("[heightmap_triangle_sampler] ERROR");
        $finish;
    end

endmodule

[filelist.f]
rtl/hts_pkg.sv
rtl/hts_ram.sv
rtl/hts_core.sv
rtl/heightmap_triangle_sampler.sv
test/heightmap_triangle_sampler_test.sv
